// ===== sv/stream_reconnect_backoff_fsm_macros.svh =====
// Assertion macros for the stream reconnect backoff block.
// Expects clk and arst_n in the scope of each use.
`ifndef STREAM_RECONNECT_BACKOFF_FSM_MACROS_SVH
`define STREAM_RECONNECT_BACKOFF_FSM_MACROS_SVH

// same-cycle implication, checked out of reset
`define SRB_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srb assertion failed");

// next-cycle implication, checked out of reset
`define SRB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srb assertion failed");

`endif

// ===== sv/srb_pkg.sv =====
// Shared types and codes for the stream reconnect backoff block.
// No dependencies; compiled before all other files.
`timescale 1ns / 1ps

package srb_pkg;

	localparam int DELAY_BITS_DEF   = 20;
	localparam int ATTEMPT_BITS_DEF = 4;

	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_ATTEMPTS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_DELAY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_DELAY    = 2'd2;

	localparam logic [3:0]  MAX_ATTEMPTS_RST = 4'd3;
	localparam logic [19:0] FIRST_DELAY_RST  = 20'd1000;
	localparam logic [19:0] MAX_DELAY_RST    = 20'd30000;

	localparam logic [2:0] CMD_PLAY          = 3'd0;
	localparam logic [2:0] CMD_STOP          = 3'd1;
	localparam logic [2:0] CMD_IDLE_RPT      = 3'd2;
	localparam logic [2:0] CMD_CORE_IDLE_RPT = 3'd3;
	localparam logic [2:0] CMD_END_OF_STREAM = 3'd4;
	localparam logic [2:0] CMD_LOAD_REJECTED = 3'd5;
	localparam logic [2:0] CMD_TICK          = 3'd6;

	localparam logic [1:0] ST_IDLE       = 2'd0;
	localparam logic [1:0] ST_CONNECTING = 2'd1;
	localparam logic [1:0] ST_PLAYING    = 2'd2;
	localparam logic [1:0] ST_FAILED     = 2'd3;

	localparam logic [1:0] KIND_NONE        = 2'd0;
	localparam logic [1:0] KIND_PLAY_FAILED = 2'd1;
	localparam logic [1:0] KIND_GAVE_UP     = 2'd2;
	localparam logic [1:0] KIND_NO_START    = 2'd3;

	typedef struct packed {
		logic [2:0]        command;
		logic              flag_value;
		logic              end_was_error;
		logic signed [7:0] error_code;
		logic              url_given;
	} req_t;

	typedef struct packed {
		logic [1:0]        player_state;
		logic              issue_load;
		logic              request_status;
		logic [1:0]        error_kind;
		logic signed [7:0] error_code_out;
		logic [3:0]        attempts_used;
		logic              retry_waiting;
	} rsp_t;

	typedef struct packed {
		logic [3:0]  try_budget;
		logic [19:0] base_wait_ticks;
		logic [19:0] wait_cap_ticks;
	} cfg_t;

endpackage

// ===== sv/srb_ifs.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on srb_pkg for the payload types.
`timescale 1ns / 1ps

interface srb_req_if;
	import srb_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface srb_rsp_if;
	import srb_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/srb_cfg.sv =====
// Configuration register file: three write-only registers.
// Depends on srb_pkg.
`timescale 1ns / 1ps

module srb_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              we,
	input  logic [srb_pkg::CFG_IDX_W-1:0]     idx,
	input  logic [srb_pkg::CFG_DATA_W-1:0]    data,
	output srb_pkg::cfg_t                     cfg
);
	import srb_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.try_budget      <= MAX_ATTEMPTS_RST;
			cfg_q.base_wait_ticks <= FIRST_DELAY_RST;
			cfg_q.wait_cap_ticks  <= MAX_DELAY_RST;
		end else if (we) begin
			unique case (idx)
				CFG_IDX_MAX_ATTEMPTS: cfg_q.try_budget      <= data[3:0];
				CFG_IDX_FIRST_DELAY:  cfg_q.base_wait_ticks <= data;
				CFG_IDX_MAX_DELAY:    cfg_q.wait_cap_ticks  <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== sv/srb_backoff.sv =====
// Retry delay: first delay shifted by (attempt - 1), saturated at the cap.
// Pure combinational; depends on nothing else.
`timescale 1ns / 1ps

module srb_backoff #(
	parameter int DELAY_BITS   = 20,
	parameter int ATTEMPT_BITS = 4
) (
	input  logic [ATTEMPT_BITS-1:0] attempt,
	input  logic [DELAY_BITS-1:0]   base_wait,
	input  logic [DELAY_BITS-1:0]   wait_cap,
	output logic [DELAY_BITS-1:0]   delay
);
	logic [ATTEMPT_BITS-1:0]   shamt;
	logic [2*DELAY_BITS-1:0]   shifted;
	logic                      ovf;

	always_comb begin
		shamt   = (attempt == '0) ? '0 : attempt - ATTEMPT_BITS'(1);
		shifted = {{DELAY_BITS{1'b0}}, base_wait} << shamt;
		ovf     = ((32'(shamt) >= DELAY_BITS) && (base_wait != '0)) ||
			(shifted[2*DELAY_BITS-1:DELAY_BITS] != '0);
		if (ovf || (shifted[DELAY_BITS-1:0] > wait_cap)) begin
			delay = wait_cap;
		end else begin
			delay = shifted[DELAY_BITS-1:0];
		end
	end
endmodule

// ===== sv/srb_core.sv =====
// Connection state registers and the per-request next-state logic.
// Depends on srb_pkg and srb_backoff.
`timescale 1ns / 1ps

module srb_core #(
	parameter int DELAY_BITS   = 20,
	parameter int ATTEMPT_BITS = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  srb_pkg::req_t req_data,
	input  srb_pkg::cfg_t cfg,
	output srb_pkg::rsp_t result
);
	import srb_pkg::*;

	localparam int CMP_W = (ATTEMPT_BITS > 4) ? ATTEMPT_BITS : 4;

	logic                    failed_q, loading_q, idle_q, core_idle_q, selected_q, armed_q;
	logic [ATTEMPT_BITS-1:0] attempt_q;
	logic [DELAY_BITS-1:0]   countdown_q;
	logic signed [7:0]       kcode_q;
	logic [1:0]              kkind_q;

	logic                    failed_d, loading_d, idle_d, core_idle_d, selected_d, armed_d;
	logic [ATTEMPT_BITS-1:0] attempt_d, attempt_inc;
	logic [DELAY_BITS-1:0]   countdown_d, delay;
	logic signed [7:0]       kcode_d;
	logic [1:0]              kkind_d;
	logic                    load, refused;

	function automatic logic [1:0] state_of(logic f, logic l, logic i, logic c);
		logic [1:0] s;
		if (f)      s = ST_FAILED;
		else if (l) s = ST_CONNECTING;
		else if (i) s = ST_IDLE;
		else if (c) s = ST_CONNECTING;
		else        s = ST_PLAYING;
		return s;
	endfunction

	assign attempt_inc = attempt_q + ATTEMPT_BITS'(1);

	srb_backoff #(
		.DELAY_BITS   (DELAY_BITS),
		.ATTEMPT_BITS (ATTEMPT_BITS)
	) u_backoff (
		.attempt   (attempt_inc),
		.base_wait (DELAY_BITS'(cfg.base_wait_ticks)),
		.wait_cap  (DELAY_BITS'(cfg.wait_cap_ticks)),
		.delay     (delay)
	);

	always_comb begin
		failed_d    = failed_q;
		loading_d   = loading_q;
		idle_d      = idle_q;
		core_idle_d = core_idle_q;
		selected_d  = selected_q;
		armed_d     = armed_q;
		attempt_d   = attempt_q;
		countdown_d = countdown_q;
		kcode_d     = kcode_q;
		kkind_d     = kkind_q;
		load        = 1'b0;
		refused     = 1'b0;

		unique case (req_data.command) inside
			CMD_PLAY: begin
				if (!req_data.url_given) begin
					refused = 1'b1;
				end else begin
					loading_d   = 1'b1;
					failed_d    = 1'b0;
					kcode_d     = '0;
					kkind_d     = KIND_NONE;
					attempt_d   = '0;
					armed_d     = 1'b0;
					countdown_d = '0;
					selected_d  = 1'b1;
					load        = 1'b1;
				end
			end
			CMD_STOP: begin
				selected_d  = 1'b0;
				loading_d   = 1'b0;
				failed_d    = 1'b0;
				kcode_d     = '0;
				kkind_d     = KIND_NONE;
				attempt_d   = '0;
				armed_d     = 1'b0;
				countdown_d = '0;
			end
			CMD_IDLE_RPT, CMD_CORE_IDLE_RPT: begin
				if (req_data.command == CMD_IDLE_RPT) begin
					idle_d = req_data.flag_value;
					if (!req_data.flag_value) loading_d = 1'b0;
				end else begin
					core_idle_d = req_data.flag_value;
				end
				if (state_of(failed_d, loading_d, idle_d, core_idle_d) == ST_PLAYING) begin
					attempt_d = '0;
				end
			end
			CMD_END_OF_STREAM: begin
				if (req_data.end_was_error) begin
					if (!selected_q) begin
						loading_d   = 1'b0;
						armed_d     = 1'b0;
						countdown_d = '0;
					end else if (CMP_W'(attempt_q) < CMP_W'(cfg.try_budget)) begin
						attempt_d   = attempt_inc;
						loading_d   = 1'b1;
						failed_d    = 1'b0;
						kcode_d     = req_data.error_code;
						kkind_d     = KIND_PLAY_FAILED;
						countdown_d = delay;
						armed_d     = 1'b1;
					end else begin
						loading_d   = 1'b0;
						failed_d    = 1'b1;
						armed_d     = 1'b0;
						countdown_d = '0;
						kcode_d     = req_data.error_code;
						kkind_d     = (attempt_q != '0) ? KIND_GAVE_UP : KIND_PLAY_FAILED;
					end
				end
			end
			CMD_LOAD_REJECTED: begin
				loading_d   = 1'b0;
				failed_d    = 1'b1;
				armed_d     = 1'b0;
				countdown_d = '0;
				kcode_d     = req_data.error_code;
				kkind_d     = KIND_NO_START;
			end
			CMD_TICK: begin
				if (armed_q && (countdown_q != '0)) countdown_d = countdown_q - DELAY_BITS'(1);
			end
			default: ;
		endcase

		// expire: disarm and reload the selected station
		if (armed_d && (countdown_d == '0)) begin
			armed_d = 1'b0;
			if (selected_d) load = 1'b1;
		end

		result.player_state   = state_of(failed_d, loading_d, idle_d, core_idle_d);
		result.issue_load     = load;
		result.request_status = refused;
		result.error_kind     = failed_d ? kkind_d : KIND_NONE;
		result.error_code_out = failed_d ? kcode_d : 8'sd0;
		result.attempts_used  = 4'(attempt_d);
		result.retry_waiting  = armed_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q    <= 1'b0;
			loading_q   <= 1'b0;
			idle_q      <= 1'b1;
			core_idle_q <= 1'b1;
			selected_q  <= 1'b0;
			armed_q     <= 1'b0;
			attempt_q   <= '0;
			countdown_q <= '0;
			kcode_q     <= '0;
			kkind_q     <= KIND_NONE;
		end else if (accept) begin
			failed_q    <= failed_d;
			loading_q   <= loading_d;
			idle_q      <= idle_d;
			core_idle_q <= core_idle_d;
			selected_q  <= selected_d;
			armed_q     <= armed_d;
			attempt_q   <= attempt_d;
			countdown_q <= countdown_d;
			kcode_q     <= kcode_d;
			kkind_q     <= kkind_d;
		end
	end
endmodule

// ===== sv/srb_out_buf.sv =====
// Two-entry result buffer that drives the result channel.
// Depends on srb_pkg and srb_rsp_if.
`timescale 1ns / 1ps

module srb_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  srb_pkg::rsp_t push_data,
	output logic          push_ready,
	srb_rsp_if.source     rsp
);
	import srb_pkg::*;

	logic [1:0] count_q;
	rsp_t       head_q;
	rsp_t       tail_q;
	logic       pop;

	assign pop         = rsp.valid && rsp.ready;
	assign push_ready  = (count_q != 2'd2);
	assign rsp.valid   = (count_q != 2'd0);
	assign rsp.payload = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b11: begin
				if (count_q == 2'd1) begin
					head_q <= push_data;
				end else begin
					head_q <= tail_q;
					tail_q <= push_data;
				end
			end
			2'b10: begin
				if (count_q == 2'd0) head_q <= push_data;
				else tail_q <= push_data;
			end
			2'b01: head_q <= tail_q;
			default: ;
		endcase
	end
endmodule

// ===== sv/stream_reconnect_backoff_fsm.sv =====
// Stream reconnect controller with exponential retry backoff.
// Each result is registered in the result buffer when its request is accepted and is presented from its head.
// Throughput: one request per cycle while the result buffer is not full; the state update is combinational.
// A two-entry result buffer keeps requests flowing while one result is stalled.
// Reset (arst_n low, async) restores register defaults and the idle start state.
`timescale 1ns / 1ps

`include "stream_reconnect_backoff_fsm_macros.svh"

module stream_reconnect_backoff_fsm #(
	parameter int DELAY_BITS   = srb_pkg::DELAY_BITS_DEF,
	parameter int ATTEMPT_BITS = srb_pkg::ATTEMPT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	srb_req_if.sink                        req,
	srb_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [srb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import srb_pkg::*;

	cfg_t cfg;
	rsp_t result;
	logic accept;
	logic buf_ready;

	assign req.ready = buf_ready;
	assign accept    = req.valid && buf_ready;

	srb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	srb_core #(
		.DELAY_BITS   (DELAY_BITS),
		.ATTEMPT_BITS (ATTEMPT_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req_data (req.payload),
		.cfg      (cfg),
		.result   (result)
	);

	srb_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  (result),
		.push_ready (buf_ready),
		.rsp        (rsp)
	);

	`SRB_ASSERT_IMP(a_kind_iff_failed, accept, ((result.error_kind != KIND_NONE) == (result.player_state == ST_FAILED)))
	`SRB_ASSERT_IMP(a_wait_not_failed, accept && result.retry_waiting, result.player_state != ST_FAILED)
	`SRB_ASSERT_IMP(a_refused_no_load, accept && result.request_status, !result.issue_load)
	`SRB_ASSERT_NEXT(a_stop_clears, accept && (req.payload.command == CMD_STOP), !u_core.armed_q)
endmodule
